// ===== design/rsc_pkg.sv =====
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared widths, register indexes and transaction side-band types for the
// steer-and-clamp pipeline.
// ----------------------------------------------------------------------------
package rsc_pkg;

  // coordinate format
  localparam int CoordW   = 32;
  localparam int FracBits = 16;

  // derived widths
  localparam int MagW  = CoordW + 1;         // |goal - start|
  localparam int StepW = CoordW - 1;         // step length register
  localparam int SumW  = 2 * CoordW + 2;     // sum of three squares
  localparam int RootW = SumW / 2;           // floor(sqrt(sum))
  localparam int RemW  = RootW + 3;          // sqrt partial remainder
  localparam int NumW  = MagW + StepW;       // |d| * step
  localparam int QuoW  = StepW;              // offset magnitude
  localparam int CfgIdxW = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_X_LOW  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_X_HIGH = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_Y_LOW  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_Y_HIGH = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_Z_LOW  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_Z_HIGH = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_STEP   = 3'd6;

  // reset values
  localparam logic [CoordW-1:0] CoordMin  = {1'b1, {(CoordW-1){1'b0}}};
  localparam logic [CoordW-1:0] CoordMax  = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic [StepW-1:0]  StepReset = StepW'(64'd1 << FracBits);

  // side-band carried alongside the length computation to the output
  typedef struct packed {
    logic [2:0]              neg;
    logic [2:0][CoordW-1:0]  start;
    logic                    zero;
  } tail_t;

  // side-band carried through the square root
  typedef struct packed {
    logic [2:0][NumW-1:0] num;
    tail_t                tail;
  } sq_meta_t;

endpackage

// ===== design/rsc_sqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// rsc_sqrt_pipe
// Fully pipelined restoring integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module rsc_sqrt_pipe (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_vld,
  input  logic [rsc_pkg::SumW-1:0]  in_rad,
  input  rsc_pkg::sq_meta_t         in_meta,
  output logic                      out_vld,
  output logic [rsc_pkg::RootW-1:0] out_root,
  output rsc_pkg::sq_meta_t         out_meta
);

  localparam int NStg = rsc_pkg::RootW;

  typedef struct packed {
    logic [rsc_pkg::RemW-1:0]  rem;
    logic [rsc_pkg::RootW-1:0] root;
    logic [rsc_pkg::SumW-1:0]  rad;
  } sq_st_t;

  logic              vld_r  [0:NStg];
  sq_st_t            st_r   [0:NStg];
  rsc_pkg::sq_meta_t meta_r [0:NStg];

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    st_r[0].rem  <= '0;
    st_r[0].root <= '0;
    st_r[0].rad  <= in_rad;
    meta_r[0]    <= in_meta;
  end

  // one root bit per stage
  for (genvar k = 1; k <= NStg; k++) begin : g_stg
    logic [rsc_pkg::RemW-1:0] rem_sh;
    logic [rsc_pkg::RemW-1:0] trial;
    sq_st_t                   st_nxt;

    always_comb begin
      rem_sh = {st_r[k-1].rem[rsc_pkg::RemW-3:0],
                st_r[k-1].rad[rsc_pkg::SumW-1 -: 2]};
      trial  = {1'b0, st_r[k-1].root, 2'b01};
      st_nxt.rad = {st_r[k-1].rad[rsc_pkg::SumW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        st_nxt.rem  = rem_sh - trial;
        st_nxt.root = {st_r[k-1].root[rsc_pkg::RootW-2:0], 1'b1};
      end else begin
        st_nxt.rem  = rem_sh;
        st_nxt.root = {st_r[k-1].root[rsc_pkg::RootW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      st_r[k]   <= st_nxt;
      meta_r[k] <= meta_r[k-1];
    end
  end

  assign out_vld  = vld_r[NStg];
  assign out_root = st_r[NStg].root;
  assign out_meta = meta_r[NStg];

endmodule

// ===== design/rsc_div_pipe.sv =====
// ----------------------------------------------------------------------------
// rsc_div_pipe
// Three-lane pipelined restoring divider, one quotient bit per stage.
// The quotient is known to fit QuoW bits (|d| <= root).
// ----------------------------------------------------------------------------
module rsc_div_pipe (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_vld,
  input  logic [rsc_pkg::RootW-1:0]           in_den,
  input  logic [2:0][rsc_pkg::NumW-1:0]       in_num,
  input  rsc_pkg::tail_t                      in_tail,
  output logic                                out_vld,
  output logic [2:0][rsc_pkg::QuoW-1:0]       out_quo,
  output rsc_pkg::tail_t                      out_tail
);

  localparam int NStg = rsc_pkg::QuoW;

  typedef struct packed {
    logic [rsc_pkg::RootW-1:0] rem;
    logic [rsc_pkg::StepW-1:0] low;
    logic [rsc_pkg::QuoW-1:0]  quo;
  } dv_st_t;

  logic                      vld_r  [0:NStg];
  logic [rsc_pkg::RootW-1:0] den_r  [0:NStg];
  dv_st_t [2:0]              st_r   [0:NStg];
  rsc_pkg::tail_t            tail_r [0:NStg];

  // input register: top bits of the numerator seed the remainder
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    den_r[0]  <= in_den;
    tail_r[0] <= in_tail;
    for (int a = 0; a < 3; a++) begin
      st_r[0][a].rem <= in_num[a][rsc_pkg::NumW-1:rsc_pkg::StepW];
      st_r[0][a].low <= in_num[a][rsc_pkg::StepW-1:0];
      st_r[0][a].quo <= '0;
    end
  end

  for (genvar k = 1; k <= NStg; k++) begin : g_stg
    dv_st_t [2:0] st_nxt;

    // shift in one numerator bit per lane, subtract if it fits
    always_comb begin
      for (int a = 0; a < 3; a++) begin
        logic [rsc_pkg::RootW:0] t;
        t = {st_r[k-1][a].rem, st_r[k-1][a].low[rsc_pkg::StepW-1]};
        st_nxt[a].low = {st_r[k-1][a].low[rsc_pkg::StepW-2:0], 1'b0};
        if (t >= {1'b0, den_r[k-1]}) begin
          st_nxt[a].rem = rsc_pkg::RootW'(t - {1'b0, den_r[k-1]});
          st_nxt[a].quo = {st_r[k-1][a].quo[rsc_pkg::QuoW-2:0], 1'b1};
        end else begin
          st_nxt[a].rem = t[rsc_pkg::RootW-1:0];
          st_nxt[a].quo = {st_r[k-1][a].quo[rsc_pkg::QuoW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      st_r[k]   <= st_nxt;
      den_r[k]  <= den_r[k-1];
      tail_r[k] <= tail_r[k-1];
    end
  end

  assign out_vld  = vld_r[NStg];
  assign out_tail = tail_r[NStg];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      out_quo[a] = st_r[NStg][a].quo;
    end
  end

endmodule

// ===== design/rrt_steer_clamp_top.sv =====
// ----------------------------------------------------------------------------
// rrt_steer_clamp_top
// Steers a 3-D start point one step length toward a goal and clamps each
// axis to its bounds. Exact integer length, pipelined root and divide.
//
//   Channel  Ports                                  Handshake
//   input    in_start_*, in_goal_*                  start & !busy
//   result   out_new_*, out_zero_length             out_valid, one cycle
//   config   cfg_index, cfg_wdata                   cfg_we
//
// One transaction accepted every cycle; busy is never raised.
// The pipeline has 2 front stages, RootW+1 sqrt stages, QuoW+1 divide
// stages and the clamp/output register.
// Synchronous active-low reset clears the valid pipeline and the configuration registers.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module rrt_steer_clamp_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [rsc_pkg::CoordW-1:0] in_start_x,
  input  logic signed [rsc_pkg::CoordW-1:0] in_start_y,
  input  logic signed [rsc_pkg::CoordW-1:0] in_start_z,
  input  logic signed [rsc_pkg::CoordW-1:0] in_goal_x,
  input  logic signed [rsc_pkg::CoordW-1:0] in_goal_y,
  input  logic signed [rsc_pkg::CoordW-1:0] in_goal_z,
  output logic                             out_valid,
  output logic signed [rsc_pkg::CoordW-1:0] out_new_x,
  output logic signed [rsc_pkg::CoordW-1:0] out_new_y,
  output logic signed [rsc_pkg::CoordW-1:0] out_new_z,
  output logic                             out_zero_length,
  input  logic                             cfg_we,
  input  logic [rsc_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [rsc_pkg::CoordW-1:0]       cfg_wdata
);

  localparam int CW = rsc_pkg::CoordW;

  // configuration registers
  logic [2:0][CW-1:0]           low_r;
  logic [2:0][CW-1:0]           high_r;
  logic [rsc_pkg::StepW-1:0]    step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        low_r[a]  <= rsc_pkg::CoordMin;
        high_r[a] <= rsc_pkg::CoordMax;
      end
      step_r <= rsc_pkg::StepReset;
    end else if (cfg_we) begin
      case (cfg_index)
        rsc_pkg::CFG_X_LOW:  low_r[0]  <= cfg_wdata;
        rsc_pkg::CFG_X_HIGH: high_r[0] <= cfg_wdata;
        rsc_pkg::CFG_Y_LOW:  low_r[1]  <= cfg_wdata;
        rsc_pkg::CFG_Y_HIGH: high_r[1] <= cfg_wdata;
        rsc_pkg::CFG_Z_LOW:  low_r[2]  <= cfg_wdata;
        rsc_pkg::CFG_Z_HIGH: high_r[2] <= cfg_wdata;
        rsc_pkg::CFG_STEP:   step_r    <= cfg_wdata[rsc_pkg::StepW-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 1: differences, magnitudes and signs
  logic [2:0][CW-1:0] s_in, g_in;
  assign s_in = {in_start_z, in_start_y, in_start_x};
  assign g_in = {in_goal_z, in_goal_y, in_goal_x};

  logic                             v1_r;
  logic [2:0][rsc_pkg::MagW-1:0]    mag1_r;
  logic [2:0]                       neg1_r;
  logic [2:0][CW-1:0]               st1_r;
  logic [2:0][rsc_pkg::MagW-1:0]    mag1_nxt;
  logic [2:0]                       neg1_nxt;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [CW:0] d;
      d = $signed({g_in[a][CW-1], g_in[a]}) - $signed({s_in[a][CW-1], s_in[a]});
      neg1_nxt[a] = d[CW];
      mag1_nxt[a] = d[CW] ? rsc_pkg::MagW'(-d) : rsc_pkg::MagW'(d);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    mag1_r <= mag1_nxt;
    neg1_r <= neg1_nxt;
    st1_r  <= s_in;
  end

  // stage 2: squares and |d| * step (top magnitude bit only on 2^CW)
  logic                             v2_r;
  logic [2:0][2*CW:0]               sq2_r;
  logic [2:0][rsc_pkg::NumW-1:0]    num2_r;
  logic [2:0]                       neg2_r;
  logic [2:0][CW-1:0]               st2_r;
  logic [2:0][2*CW:0]               sq2_nxt;
  logic [2:0][rsc_pkg::NumW-1:0]    num2_nxt;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (mag1_r[a][CW]) begin
        sq2_nxt[a]  = {1'b1, {(2*CW){1'b0}}};
        num2_nxt[a] = {1'b0, step_r, {CW{1'b0}}};
      end else begin
        sq2_nxt[a]  = {1'b0, (2*CW)'(mag1_r[a][CW-1:0]) * (2*CW)'(mag1_r[a][CW-1:0])};
        num2_nxt[a] = rsc_pkg::NumW'(mag1_r[a][CW-1:0]) * rsc_pkg::NumW'(step_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    sq2_r  <= sq2_nxt;
    num2_r <= num2_nxt;
    neg2_r <= neg1_r;
    st2_r  <= st1_r;
  end

  // sum of squares into the root pipeline
  logic [rsc_pkg::SumW-1:0] sum2;
  rsc_pkg::sq_meta_t        meta2;

  always_comb begin
    sum2 = rsc_pkg::SumW'(sq2_r[0]) + rsc_pkg::SumW'(sq2_r[1])
         + rsc_pkg::SumW'(sq2_r[2]);
    meta2.num        = num2_r;
    meta2.tail.neg   = neg2_r;
    meta2.tail.start = st2_r;
    meta2.tail.zero  = (sum2 == '0);
  end

  logic                      sq_vld;
  logic [rsc_pkg::RootW-1:0] sq_root;
  rsc_pkg::sq_meta_t         sq_meta;

  rsc_sqrt_pipe u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v2_r),
    .in_rad   (sum2),
    .in_meta  (meta2),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_meta (sq_meta)
  );

  logic                              dv_vld;
  logic [2:0][rsc_pkg::QuoW-1:0]     dv_quo;
  rsc_pkg::tail_t                    dv_tail;

  rsc_div_pipe u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (sq_vld),
    .in_den   (sq_root),
    .in_num   (sq_meta.num),
    .in_tail  (sq_meta.tail),
    .out_vld  (dv_vld),
    .out_quo  (dv_quo),
    .out_tail (dv_tail)
  );

  // final stage: apply signed offset, clamp low then high
  logic [2:0][CW-1:0] new_nxt;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [CW+1:0] v;
      logic signed [CW+1:0] off;
      logic signed [CW+1:0] lo;
      logic signed [CW+1:0] hi;
      off = $signed({{(CW+2-rsc_pkg::QuoW){1'b0}}, dv_quo[a]});
      if (dv_tail.neg[a]) begin
        off = -off;
      end
      lo = $signed({{2{low_r[a][CW-1]}}, low_r[a]});
      hi = $signed({{2{high_r[a][CW-1]}}, high_r[a]});
      v  = $signed({{2{dv_tail.start[a][CW-1]}}, dv_tail.start[a]});
      if (!dv_tail.zero) begin
        v = v + off;
      end
      if (v < lo) begin
        v = lo;
      end
      if (v >= hi) begin
        v = hi;
      end
      new_nxt[a] = v[CW-1:0];
    end
  end

  logic               out_valid_r;
  logic [2:0][CW-1:0] new_r;
  logic               zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    new_r  <= new_nxt;
    zero_r <= dv_tail.zero;
  end

  assign out_valid       = out_valid_r;
  assign out_new_x       = new_r[0];
  assign out_new_y       = new_r[1];
  assign out_new_z       = new_r[2];
  assign out_zero_length = zero_r;

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rrt_steer_clamp_top. A directed table covers
// coordinate extremes, zero-length steps and clamping overflow. Random point
// pairs then run under several bound and step-length settings. Each result
// is checked against its table value or an in-bench steer/clamp model using
// the exact integer square root and the truncating divide.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [rsc_pkg::CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   zero_len;
  } steer_res_t;

  typedef struct {
    coord_t     s[3];
    coord_t     g[3];
    bit         typed;
    steer_res_t res;
  } steer_row_t;

  localparam logic [rsc_pkg::CfgIdxW-1:0] CFG_UNUSED = 3'd7;
  localparam int PIPE_LAT  = 80;
  localparam int CYC_LIMIT = 200000;
  localparam int N_PHASE   = 5;
  localparam int PHASE_ITEMS = 210;
  localparam coord_t ONE  = 32'sh0001_0000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  coord_t in_start_x, in_start_y, in_start_z;
  coord_t in_goal_x, in_goal_y, in_goal_z;
  logic out_valid;
  coord_t out_new_x, out_new_y, out_new_z;
  logic out_zero_length;
  logic cfg_we;
  logic [rsc_pkg::CfgIdxW-1:0] cfg_index;
  logic [rsc_pkg::CoordW-1:0] cfg_wdata;

  // shadow of the block's registers
  coord_t low_bnd[3];
  coord_t high_bnd[3];
  logic [rsc_pkg::StepW-1:0] step_len;

  steer_res_t steer_q[$];
  int n_err;
  int n_sent;
  int cyc;

  rrt_steer_clamp_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_start_z     (in_start_z),
    .in_goal_x      (in_goal_x),
    .in_goal_y      (in_goal_y),
    .in_goal_z      (in_goal_z),
    .out_valid      (out_valid),
    .out_new_x      (out_new_x),
    .out_new_y      (out_new_y),
    .out_new_z      (out_new_z),
    .out_zero_length(out_zero_length),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // run limit
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYC_LIMIT) begin
      $display("%0t timeout", $time);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // steer toward goal by step_len, then clamp each axis
  function automatic steer_res_t steer_predict(coord_t s[3], coord_t g[3]);
    logic signed [rsc_pkg::CoordW:0] d;
    logic [rsc_pkg::CoordW:0] mag[3];
    logic neg[3];
    logic [67:0] sum;
    logic [67:0] sq;
    logic [33:0] root;
    logic [33:0] cand;
    longint unsigned q;
    longint v;
    longint lo;
    longint hi;
    coord_t o[3];
    steer_res_t r;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      d = {g[i][rsc_pkg::CoordW-1], g[i]} - {s[i][rsc_pkg::CoordW-1], s[i]};
      neg[i] = d[rsc_pkg::CoordW];
      mag[i] = neg[i] ? -d : d;
      sum += 68'(mag[i]) * 68'(mag[i]);
    end
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      cand = root | (34'd1 << b);
      sq = 68'(cand) * 68'(cand);
      if (sq <= sum) root = cand;
    end
    for (int i = 0; i < 3; i++) begin
      v = longint'(s[i]);
      if (sum != 0 && root != 0) begin
        q = (64'(mag[i]) * 64'(step_len)) / 64'(root);
        v = neg[i] ? v - longint'(q) : v + longint'(q);
      end
      lo = longint'(low_bnd[i]);
      hi = longint'(high_bnd[i]);
      if (v < lo) v = lo;
      if (v >= hi) v = hi;
      o[i] = coord_t'(v);
    end
    r.x = o[0];
    r.y = o[1];
    r.z = o[2];
    r.zero_len = (sum == 0);
    return r;
  endfunction

  // register write, shadow updated alongside
  task automatic reg_write(logic [rsc_pkg::CfgIdxW-1:0] idx,
                           logic [rsc_pkg::CoordW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      rsc_pkg::CFG_X_LOW:  low_bnd[0]  = val;
      rsc_pkg::CFG_X_HIGH: high_bnd[0] = val;
      rsc_pkg::CFG_Y_LOW:  low_bnd[1]  = val;
      rsc_pkg::CFG_Y_HIGH: high_bnd[1] = val;
      rsc_pkg::CFG_Z_LOW:  low_bnd[2]  = val;
      rsc_pkg::CFG_Z_HIGH: high_bnd[2] = val;
      rsc_pkg::CFG_STEP:   step_len    = val[rsc_pkg::StepW-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one transaction: optional idle gap, then hold start until accepted
  task automatic send_pair(coord_t s[3], coord_t g[3], bit typed, steer_res_t res);
    int gap;
    bit quiet;
    quiet = (n_sent >= 400 && n_sent < 600);
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < 17) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_start_x <= s[0];
    in_start_y <= s[1];
    in_start_z <= s[2];
    in_goal_x  <= g[0];
    in_goal_y  <= g[1];
    in_goal_z  <= g[2];
    do @(posedge clk); while (busy);
    steer_q.insert(steer_q.size(), typed ? res : steer_predict(s, g));
    n_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (steer_q.size() > 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  function automatic coord_t rand_coord();
    return coord_t'($urandom());
  endfunction

  // nearby goals, equal points, extreme goals and full-range pairs
  task automatic send_random();
    coord_t s[3];
    coord_t g[3];
    steer_res_t none;
    int mode;
    none = '0;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      s[i] = rand_coord();
      case (mode)
        0: g[i] = s[i];
        1, 2, 3, 4: g[i] = ($urandom_range(0, 3) == 0) ? s[i] :
                           s[i] + coord_t'($signed($urandom_range(0, 32'h0008_0000)) -
                                           32'sh0004_0000);
        8: g[i] = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
        9: g[i] = $urandom_range(0, 1) ? s[i] : rand_coord();
        default: g[i] = rand_coord();
      endcase
    end
    send_pair(s, g, 1'b0, none);
  endtask

  // result checker
  always @(posedge clk) begin
    steer_res_t got;
    steer_res_t want;
    if (rst_n && out_valid) begin
      got = '{out_new_x, out_new_y, out_new_z, out_zero_length};
      if (steer_q.size() == 0) begin
        $display("%0t unexpected result x=%h y=%h z=%h zl=%b", $time,
                 got.x, got.y, got.z, got.zero_len);
        n_err++;
      end else begin
        want = steer_q.pop_front();
        if (got.x != want.x) begin
          $display("%0t new_x exp %h got %h", $time, want.x, got.x);
          n_err++;
        end
        if (got.y != want.y) begin
          $display("%0t new_y exp %h got %h", $time, want.y, got.y);
          n_err++;
        end
        if (got.z != want.z) begin
          $display("%0t new_z exp %h got %h", $time, want.z, got.z);
          n_err++;
        end
        if (got.zero_len != want.zero_len) begin
          $display("%0t zero_length exp %b got %b", $time, want.zero_len, got.zero_len);
          n_err++;
        end
      end
    end
  end

  steer_row_t dir_tbl[14];

  initial begin
    coord_t mn;
    coord_t mx;
    mn = 32'sh8000_0000;
    mx = 32'sh7fff_ffff;
    n_err  = 0;
    n_sent = 0;
    cyc    = 0;
    rst_n      <= 1'b0;
    start      <= 1'b0;
    in_start_x <= '0;
    in_start_y <= '0;
    in_start_z <= '0;
    in_goal_x  <= '0;
    in_goal_y  <= '0;
    in_goal_z  <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= '0;
    cfg_wdata  <= '0;
    for (int i = 0; i < 3; i++) begin
      low_bnd[i]  = rsc_pkg::CoordMin;
      high_bnd[i] = rsc_pkg::CoordMax;
    end
    step_len = rsc_pkg::StepReset;

    // directed table, reset bounds and unit step
    dir_tbl[0]  = '{'{0, 0, 0}, '{0, 0, 0}, 1, '{0, 0, 0, 1'b1}};
    dir_tbl[1]  = '{'{mn, mn, mn}, '{mn, mn, mn}, 1, '{mn, mn, mn, 1'b1}};
    dir_tbl[2]  = '{'{mx, mx, mx}, '{mx, mx, mx}, 1, '{mx, mx, mx, 1'b1}};
    dir_tbl[3]  = '{'{0, 0, 0}, '{ONE, 0, 0}, 1, '{ONE, 0, 0, 1'b0}};
    dir_tbl[4]  = '{'{0, 0, 0}, '{0, -3 * ONE, 0}, 1, '{0, -ONE, 0, 1'b0}};
    dir_tbl[5]  = '{'{0, 0, 0}, '{0, 0, mx}, 1, '{0, 0, ONE, 1'b0}};
    dir_tbl[6]  = '{'{1, 0, 0}, '{0, 0, 0}, 1, '{1 - ONE, 0, 0, 1'b0}};
    dir_tbl[7]  = '{'{mx, 0, 0}, '{mx, 0, 1}, 1, '{mx, 0, ONE, 1'b0}};
    // step past the coordinate range clamps to the extreme
    dir_tbl[8]  = '{'{mx - 5, 0, 0}, '{mx, 0, 0}, 1, '{mx, 0, 0, 1'b0}};
    dir_tbl[9]  = '{'{mn + 5, 0, 0}, '{mn, 0, 0}, 1, '{mn, 0, 0, 1'b0}};
    dir_tbl[10] = '{'{mn, mn, mn}, '{mx, mx, mx}, 0, '0};
    dir_tbl[11] = '{'{mx, mx, mx}, '{mn, mn, mn}, 0, '0};
    dir_tbl[12] = '{'{mx, mn, 0}, '{mn, mx, 1}, 0, '0};
    dir_tbl[13] = '{'{-7, 12345, mn}, '{ONE, -ONE, mn + 1}, 0, '0};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tbl[k]) send_pair(dir_tbl[k].s, dir_tbl[k].g, dir_tbl[k].typed,
                                   dir_tbl[k].res);

    for (int ph = 0; ph < N_PHASE; ph++) begin
      drain_results();
      case (ph)
        1: begin
          // random bounds, random moderate step
          for (int i = 0; i < 3; i++) begin
            reg_write(rsc_pkg::CfgIdxW'(rsc_pkg::CFG_X_LOW + 2 * i),
                      32'(-$signed($urandom_range(0, 32'h4000_0000))));
            reg_write(rsc_pkg::CfgIdxW'(rsc_pkg::CFG_X_HIGH + 2 * i),
                      $urandom_range(0, 32'h4000_0000));
          end
          reg_write(rsc_pkg::CFG_STEP, $urandom_range(1, 32'h0100_0000));
        end
        2: begin
          // largest step, tight bounds
          for (int i = 0; i < 3; i++) begin
            reg_write(rsc_pkg::CfgIdxW'(rsc_pkg::CFG_X_LOW + 2 * i), -32'sh0010_0000);
            reg_write(rsc_pkg::CfgIdxW'(rsc_pkg::CFG_X_HIGH + 2 * i), 32'sh0010_0000);
          end
          reg_write(rsc_pkg::CFG_STEP, 32'h7fff_ffff);
        end
        3: begin
          // zero step; y and z low bounds above high bounds
          reg_write(rsc_pkg::CFG_STEP, 32'h0);
          reg_write(rsc_pkg::CFG_Y_LOW, 32'sh0100_0000);
          reg_write(rsc_pkg::CFG_Y_HIGH, -32'sh0100_0000);
          reg_write(rsc_pkg::CFG_Z_LOW, 32'sh7fff_ffff);
          reg_write(rsc_pkg::CFG_Z_HIGH, 32'sh8000_0000);
        end
        4: begin
          // full-range bounds; top bit of step dropped; unused index ignored
          for (int i = 0; i < 3; i++) begin
            reg_write(rsc_pkg::CfgIdxW'(rsc_pkg::CFG_X_LOW + 2 * i), rsc_pkg::CoordMin);
            reg_write(rsc_pkg::CfgIdxW'(rsc_pkg::CFG_X_HIGH + 2 * i), rsc_pkg::CoordMax);
          end
          reg_write(rsc_pkg::CFG_STEP, 32'h8000_0000 | $urandom_range(0, 32'h0040_0000));
          reg_write(CFG_UNUSED, $urandom());
        end
        default: ;
      endcase
      repeat (PHASE_ITEMS) send_random();
    end

    drain_results();
    if (n_err == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/rsc_pkg.sv
design/rsc_sqrt_pipe.sv
design/rsc_div_pipe.sv
design/rrt_steer_clamp_top.sv
verif/tb.sv
